>>> hdl/hmbs_pkg.sv
// Package for the heightmap bilinear sampler: field widths, codes, arithmetic constants.
// Depends on nothing; the design files refer to it by scoped names, the testbench imports it.

package hmbs_pkg;

    // Field widths of the channels and of the configuration port.
    localparam int ADDR_W    = 16;
    localparam int VALUE_W   = 8;
    localparam int POS_W     = 18;
    localparam int HEIGHT_W  = 16;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int FRAC_W    = 8;

    // Default map bounds and the size that reset loads.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int RESET_SIZE     = 256;
    localparam int MIN_SIZE       = 2;

    // Arithmetic of the height mapping: floor((S*100 + 32640) / 65280) - 4096.
    localparam int SUM_W      = 24;
    localparam int ROW_W      = 16;
    localparam int PROD_W     = 31;
    localparam int QUOT_W     = 15;
    localparam int SCALE_NUM  = 100;
    localparam int ROUND_BIAS = 32640;
    localparam int RECIP_255  = 257;
    localparam int DIV_LOW    = 255;
    localparam int OFFSET_H   = 4096;
    localparam int OOB_HEIGHT = -25600;

    // Result queue depth; it also bounds the number of outstanding samples.
    localparam int FIFO_DEPTH = 16;

    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_SAMPLE = 1'b1
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH  = 1'b0,
        CFG_MAP_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

>>> hdl/hmbs_req_if.sv
// Request channel of the heightmap sampler: map writes and sample positions.
// Depends on hmbs_pkg for the field widths.

interface hmbs_req_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [hmbs_pkg::ADDR_W-1:0]         texel_address;
    logic [hmbs_pkg::VALUE_W-1:0]        texel_value;
    logic signed [hmbs_pkg::POS_W-1:0]   x_pos;
    logic signed [hmbs_pkg::POS_W-1:0]   z_pos;

    modport source (
        output valid, action, texel_address, texel_value, x_pos, z_pos,
        input  ready
    );

    modport sink (
        input  valid, action, texel_address, texel_value, x_pos, z_pos,
        output ready
    );
endinterface

>>> hdl/hmbs_rsp_if.sv
// Response channel of the heightmap sampler: one interpolated height per sample.
// Depends on hmbs_pkg for the field widths.

interface hmbs_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [hmbs_pkg::HEIGHT_W-1:0] height;
    logic                                 in_bounds;

    modport source (
        output valid, height, in_bounds,
        input  ready
    );

    modport sink (
        input  valid, height, in_bounds,
        output ready
    );
endinterface

>>> hdl/heightmap_bilinear_sampler_unit.sv
// Heightmap bilinear sampler: banked byte store, sample pipeline and result queue.
// Depends on hmbs_pkg, hmbs_req_if and hmbs_rsp_if.

// The unit takes one request transaction per clock cycle while ready is high, map
// writes and samples mixed in any order, and returns one response transaction per
// sample (writes return nothing). The rate is set by the byte store: it is split into
// two banks by address parity, and each bank has one write port and two read ports,
// so the four corners of a cell (two even, two odd addresses) are read in a single
// cycle. Up to sixteen samples may be outstanding; while the response side stalls and
// all sixteen are waiting, the request side holds ready low, and writes then wait as
// well. Map writes and sample reads reach the store in the same pipeline stage, so
// every sample sees exactly the writes that came before it, with no forwarding. The
// store has no clearing pass: an entry reads as unknown until it is first written. The
// map size registers may only be changed while no transaction is in flight; values
// outside the legal range are clamped on write.

module heightmap_bilinear_sampler_unit #(
    parameter int MAX_WIDTH  = hmbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hmbs_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hmbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hmbs_pkg::CFG_W-1:0]     i_cfg_data,
    hmbs_req_if.sink                       i_req,
    hmbs_rsp_if.source                     o_rsp
);

    // Map size and coordinate widths.
    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int HB  = $clog2(MAX_HEIGHT + 1);
    localparam int XW  = ((WB + hmbs_pkg::FRAC_W) > hmbs_pkg::POS_W ?
                          (WB + hmbs_pkg::FRAC_W) : hmbs_pkg::POS_W) + 1;
    localparam int ZW  = ((HB + hmbs_pkg::FRAC_W) > hmbs_pkg::POS_W ?
                          (HB + hmbs_pkg::FRAC_W) : hmbs_pkg::POS_W) + 1;
    localparam int PW  = WB + HB;

    // Store geometry: the whole map, capped by what a write address can reach.
    localparam int MAP_CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int MEM_DEPTH = (MAP_CELLS > 2 ** hmbs_pkg::ADDR_W) ?
                               2 ** hmbs_pkg::ADDR_W : MAP_CELLS;
    localparam int BANK_D    = (MEM_DEPTH + 1) / 2;
    localparam int BAW       = $clog2(BANK_D);

    localparam int FPW = $clog2(hmbs_pkg::FIFO_DEPTH);
    localparam int FCW = $clog2(hmbs_pkg::FIFO_DEPTH + 1);

    localparam int QW = hmbs_pkg::PROD_W - hmbs_pkg::FRAC_W;

    function automatic int f_clamp(input logic [hmbs_pkg::CFG_W-1:0] v, input int hi);
        int r;
        r = int'(v);
        if (r < hmbs_pkg::MIN_SIZE) begin
            r = hmbs_pkg::MIN_SIZE;
        end else if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers, stored already clamped to the legal range.
    // ------------------------------------------------------------------
    logic [WB-1:0] r_w;
    logic [HB-1:0] r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WB'(f_clamp(hmbs_pkg::CFG_W'(hmbs_pkg::RESET_SIZE), MAX_WIDTH));
            r_h <= HB'(f_clamp(hmbs_pkg::CFG_W'(hmbs_pkg::RESET_SIZE), MAX_HEIGHT));
        end else if (i_cfg_we) begin
            unique case (hmbs_pkg::t_cfg_idx'(i_cfg_index))
                hmbs_pkg::CFG_MAP_WIDTH: begin
                    r_w <= WB'(f_clamp(i_cfg_data, MAX_WIDTH));
                end
                hmbs_pkg::CFG_MAP_HEIGHT: begin
                    r_h <= HB'(f_clamp(i_cfg_data, MAX_HEIGHT));
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request handshake and outstanding-sample credits.
    // ------------------------------------------------------------------
    logic           w_req_acc;
    logic           w_smp_acc;
    logic           w_rsp_acc;
    logic [FCW-1:0] r_credits;
    logic [FCW-1:0] n_credits;

    assign i_req.ready = (r_credits < FCW'(hmbs_pkg::FIFO_DEPTH));
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_smp_acc   = w_req_acc && (i_req.action == hmbs_pkg::ACT_SAMPLE);
    assign w_rsp_acc   = o_rsp.valid && o_rsp.ready;

    always_comb begin
        n_credits = r_credits;
        if (w_smp_acc && !w_rsp_acc) begin
            n_credits = r_credits + 1'b1;
        end else if (!w_smp_acc && w_rsp_acc) begin
            n_credits = r_credits - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credits <= '0;
        end else begin
            r_credits <= n_credits;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: recenter the position, bounds check, split integer and fraction.
    // ------------------------------------------------------------------
    logic signed [XW-1:0] w_xs;
    logic signed [ZW-1:0] w_zs;
    logic [XW-1:0]        w_x_off;
    logic [ZW-1:0]        w_z_off;
    logic [XW-1:0]        w_x_lim;
    logic [ZW-1:0]        w_z_lim;
    logic                 w_inb;

    assign w_x_off = XW'({r_w >> 1, hmbs_pkg::FRAC_W'(0)});
    assign w_z_off = ZW'({r_h >> 1, hmbs_pkg::FRAC_W'(0)});
    assign w_x_lim = XW'({WB'(r_w - 1'b1), hmbs_pkg::FRAC_W'(0)});
    assign w_z_lim = ZW'({HB'(r_h - 1'b1), hmbs_pkg::FRAC_W'(0)});
    assign w_xs    = XW'(i_req.x_pos) + $signed(w_x_off);
    assign w_zs    = ZW'(i_req.z_pos) + $signed(w_z_off);
    assign w_inb   = !w_xs[XW-1] && !w_zs[ZW-1] &&
                     ($unsigned(w_xs) < w_x_lim) && ($unsigned(w_zs) < w_z_lim);

    logic                            r_s1_smp;
    logic                            r_s1_wr;
    logic                            r_s1_inb;
    logic [hmbs_pkg::ADDR_W-1:0]     r_s1_waddr;
    logic [hmbs_pkg::VALUE_W-1:0]    r_s1_wdata;
    logic [WB-1:0]                   r_s1_x0;
    logic [HB-1:0]                   r_s1_z0;
    logic [hmbs_pkg::FRAC_W-1:0]     r_s1_fx;
    logic [hmbs_pkg::FRAC_W-1:0]     r_s1_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_smp <= 1'b0;
            r_s1_wr  <= 1'b0;
        end else begin
            r_s1_smp <= w_smp_acc;
            r_s1_wr  <= w_req_acc && (i_req.action == hmbs_pkg::ACT_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_inb   <= w_inb;
        r_s1_waddr <= i_req.texel_address;
        r_s1_wdata <= i_req.texel_value;
        r_s1_x0    <= w_xs[WB+hmbs_pkg::FRAC_W-1:hmbs_pkg::FRAC_W];
        r_s1_z0    <= w_zs[HB+hmbs_pkg::FRAC_W-1:hmbs_pkg::FRAC_W];
        r_s1_fx    <= w_xs[hmbs_pkg::FRAC_W-1:0];
        r_s1_fz    <= w_zs[hmbs_pkg::FRAC_W-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 1: cell address and bank access. Writes and reads meet the store
    // here in request order, so a sample always sees every earlier write.
    // ------------------------------------------------------------------
    logic [PW-1:0]  w_base0;
    logic [PW-1:0]  w_base1;
    logic [PW-1:0]  w_even0;
    logic [PW-1:0]  w_even1;
    logic [BAW-1:0] w_e0_idx;
    logic [BAW-1:0] w_o0_idx;
    logic [BAW-1:0] w_e1_idx;
    logic [BAW-1:0] w_o1_idx;
    logic           w_mem_we;

    assign w_base0  = PW'(r_s1_x0) + PW'(r_w) * PW'(r_s1_z0);
    assign w_base1  = w_base0 + PW'(r_w);
    // The even corner of a row pair sits at base or base+1, whichever is even.
    assign w_even0  = w_base0 + PW'(w_base0[0]);
    assign w_even1  = w_base1 + PW'(w_base1[0]);
    assign w_e0_idx = w_even0[BAW:1];
    assign w_o0_idx = w_base0[BAW:1];
    assign w_e1_idx = w_even1[BAW:1];
    assign w_o1_idx = w_base1[BAW:1];
    assign w_mem_we = r_s1_wr && (32'(r_s1_waddr) < 32'(MEM_DEPTH));

    logic [hmbs_pkg::VALUE_W-1:0] r_mem_even [BANK_D];
    logic [hmbs_pkg::VALUE_W-1:0] r_mem_odd  [BANK_D];
    logic [hmbs_pkg::VALUE_W-1:0] r_rd_e0;
    logic [hmbs_pkg::VALUE_W-1:0] r_rd_e1;
    logic [hmbs_pkg::VALUE_W-1:0] r_rd_o0;
    logic [hmbs_pkg::VALUE_W-1:0] r_rd_o1;

    always_ff @(posedge i_clk) begin
        if (w_mem_we && !r_s1_waddr[0]) begin
            r_mem_even[r_s1_waddr[BAW:1]] <= r_s1_wdata;
        end
        r_rd_e0 <= r_mem_even[w_e0_idx];
        r_rd_e1 <= r_mem_even[w_e1_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we && r_s1_waddr[0]) begin
            r_mem_odd[r_s1_waddr[BAW:1]] <= r_s1_wdata;
        end
        r_rd_o0 <= r_mem_odd[w_o0_idx];
        r_rd_o1 <= r_mem_odd[w_o1_idx];
    end

    logic                        r_s2_smp;
    logic                        r_s2_inb;
    logic                        r_s2_p0;
    logic                        r_s2_p1;
    logic [hmbs_pkg::FRAC_W-1:0] r_s2_fx;
    logic [hmbs_pkg::FRAC_W-1:0] r_s2_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_smp <= 1'b0;
        end else begin
            r_s2_smp <= r_s1_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_inb <= r_s1_inb;
        r_s2_p0  <= w_base0[0];
        r_s2_p1  <= w_base1[0];
        r_s2_fx  <= r_s1_fx;
        r_s2_fz  <= r_s1_fz;
    end

    // ------------------------------------------------------------------
    // Stage 2: undo the bank swap and blend along x within each row.
    // ------------------------------------------------------------------
    logic [hmbs_pkg::VALUE_W-1:0] w_c00;
    logic [hmbs_pkg::VALUE_W-1:0] w_c01;
    logic [hmbs_pkg::VALUE_W-1:0] w_c10;
    logic [hmbs_pkg::VALUE_W-1:0] w_c11;
    logic [hmbs_pkg::FRAC_W:0]    w_wx0;
    logic [hmbs_pkg::ROW_W-1:0]   w_row0;
    logic [hmbs_pkg::ROW_W-1:0]   w_row1;

    assign w_c00  = r_s2_p0 ? r_rd_o0 : r_rd_e0;
    assign w_c01  = r_s2_p0 ? r_rd_e0 : r_rd_o0;
    assign w_c10  = r_s2_p1 ? r_rd_o1 : r_rd_e1;
    assign w_c11  = r_s2_p1 ? r_rd_e1 : r_rd_o1;
    assign w_wx0  = {1'b1, hmbs_pkg::FRAC_W'(0)} - (hmbs_pkg::FRAC_W + 1)'(r_s2_fx);
    assign w_row0 = hmbs_pkg::ROW_W'(w_wx0) * hmbs_pkg::ROW_W'(w_c00) +
                    hmbs_pkg::ROW_W'(r_s2_fx) * hmbs_pkg::ROW_W'(w_c01);
    assign w_row1 = hmbs_pkg::ROW_W'(w_wx0) * hmbs_pkg::ROW_W'(w_c10) +
                    hmbs_pkg::ROW_W'(r_s2_fx) * hmbs_pkg::ROW_W'(w_c11);

    logic                        r_s3_smp;
    logic                        r_s3_inb;
    logic [hmbs_pkg::FRAC_W-1:0] r_s3_fz;
    logic [hmbs_pkg::ROW_W-1:0]  r_s3_row0;
    logic [hmbs_pkg::ROW_W-1:0]  r_s3_row1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_smp <= 1'b0;
        end else begin
            r_s3_smp <= r_s2_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_inb  <= r_s2_inb;
        r_s3_fz   <= r_s2_fz;
        r_s3_row0 <= w_row0;
        r_s3_row1 <= w_row1;
    end

    // ------------------------------------------------------------------
    // Stage 3: blend the two rows along z; the weights total 65536.
    // ------------------------------------------------------------------
    logic [hmbs_pkg::FRAC_W:0]  w_wz0;
    logic [hmbs_pkg::SUM_W-1:0] w_sum;

    assign w_wz0 = {1'b1, hmbs_pkg::FRAC_W'(0)} - (hmbs_pkg::FRAC_W + 1)'(r_s3_fz);
    assign w_sum = hmbs_pkg::SUM_W'(w_wz0) * hmbs_pkg::SUM_W'(r_s3_row0) +
                   hmbs_pkg::SUM_W'(r_s3_fz) * hmbs_pkg::SUM_W'(r_s3_row1);

    logic                       r_s4_smp;
    logic                       r_s4_inb;
    logic [hmbs_pkg::SUM_W-1:0] r_s4_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_smp <= 1'b0;
        end else begin
            r_s4_smp <= r_s3_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_inb <= r_s3_inb;
        r_s4_sum <= w_sum;
    end

    // ------------------------------------------------------------------
    // Stage 4: scale by 100 and add the rounding bias. Dividing by 65280 is
    // a shift by 8 followed by a divide by 255 over the next two stages.
    // ------------------------------------------------------------------
    logic [hmbs_pkg::PROD_W-1:0] w_scaled;

    assign w_scaled = hmbs_pkg::PROD_W'(r_s4_sum) * hmbs_pkg::PROD_W'(hmbs_pkg::SCALE_NUM) +
                      hmbs_pkg::PROD_W'(hmbs_pkg::ROUND_BIAS);

    logic          r_s5_smp;
    logic          r_s5_inb;
    logic [QW-1:0] r_s5_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_smp <= 1'b0;
        end else begin
            r_s5_smp <= r_s4_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_inb <= r_s4_inb;
        r_s5_u   <= w_scaled[hmbs_pkg::PROD_W-1:hmbs_pkg::FRAC_W];
    end

    // ------------------------------------------------------------------
    // Stage 5: quotient estimate u*257/65536, which is the true u/255 or one less.
    // ------------------------------------------------------------------
    logic [hmbs_pkg::PROD_W:0] w_recip;

    assign w_recip = (hmbs_pkg::PROD_W + 1)'(r_s5_u) *
                     (hmbs_pkg::PROD_W + 1)'(hmbs_pkg::RECIP_255);

    logic                        r_s6_smp;
    logic                        r_s6_inb;
    logic [QW-1:0]               r_s6_u;
    logic [hmbs_pkg::QUOT_W-1:0] r_s6_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_smp <= 1'b0;
        end else begin
            r_s6_smp <= r_s5_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_inb <= r_s5_inb;
        r_s6_u   <= r_s5_u;
        r_s6_q0  <= w_recip[2*hmbs_pkg::FRAC_W+hmbs_pkg::QUOT_W-1:2*hmbs_pkg::FRAC_W];
    end

    // ------------------------------------------------------------------
    // Stage 6: fix the estimate with one compare, remove the offset, pick the
    // out-of-bounds code, and push the result into the queue.
    // ------------------------------------------------------------------
    logic [QW-1:0]                      w_q0x255;
    logic [QW-1:0]                      w_rem;
    logic [hmbs_pkg::QUOT_W-1:0]        w_quot;
    logic signed [hmbs_pkg::HEIGHT_W-1:0] w_height;

    assign w_q0x255 = QW'({r_s6_q0, hmbs_pkg::FRAC_W'(0)}) - QW'(r_s6_q0);
    assign w_rem    = r_s6_u - w_q0x255;
    assign w_quot   = r_s6_q0 + hmbs_pkg::QUOT_W'(w_rem >= QW'(hmbs_pkg::DIV_LOW));
    assign w_height = r_s6_inb ?
                      $signed(hmbs_pkg::HEIGHT_W'(w_quot) -
                              hmbs_pkg::HEIGHT_W'(hmbs_pkg::OFFSET_H)) :
                      hmbs_pkg::HEIGHT_W'(hmbs_pkg::OOB_HEIGHT);

    // ------------------------------------------------------------------
    // Result queue. The credit count keeps it from ever overflowing.
    // ------------------------------------------------------------------
    logic signed [hmbs_pkg::HEIGHT_W-1:0] r_fifo_h  [hmbs_pkg::FIFO_DEPTH];
    logic                                 r_fifo_ib [hmbs_pkg::FIFO_DEPTH];
    logic [FPW-1:0]                       r_wr_ptr;
    logic [FPW-1:0]                       r_rd_ptr;
    logic [FCW-1:0]                       r_fifo_cnt;
    logic [FCW-1:0]                       n_fifo_cnt;

    always_comb begin
        n_fifo_cnt = r_fifo_cnt;
        if (r_s6_smp && !w_rsp_acc) begin
            n_fifo_cnt = r_fifo_cnt + 1'b1;
        end else if (!r_s6_smp && w_rsp_acc) begin
            n_fifo_cnt = r_fifo_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
        end else begin
            r_fifo_cnt <= n_fifo_cnt;
            if (r_s6_smp) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rsp_acc) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s6_smp) begin
            r_fifo_h[r_wr_ptr]  <= w_height;
            r_fifo_ib[r_wr_ptr] <= r_s6_inb;
        end
    end

    assign o_rsp.valid     = (r_fifo_cnt != '0);
    assign o_rsp.height    = r_fifo_h[r_rd_ptr];
    assign o_rsp.in_bounds = r_fifo_ib[r_rd_ptr];

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credits <= FCW'(hmbs_pkg::FIFO_DEPTH))
        else $error("outstanding sample count exceeds the result queue depth");

    a_queue_within_credits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= r_credits)
        else $error("result queue holds more entries than outstanding samples");

    a_no_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s6_smp |-> (r_fifo_cnt < FCW'(hmbs_pkg::FIFO_DEPTH)))
        else $error("sample result arrives at a full result queue");

    a_oob_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.in_bounds) |->
            (o_rsp.height == hmbs_pkg::HEIGHT_W'(hmbs_pkg::OOB_HEIGHT)))
        else $error("out-of-bounds result carries a height other than the fixed code");

    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s6_smp && r_s6_inb) |->
            (w_quot <= hmbs_pkg::QUOT_W'(hmbs_pkg::OOB_HEIGHT * -1)))
        else $error("interpolated height exceeds the full-scale value");
`endif

endmodule

>>> test/heightmap_bilinear_sampler_unit_tb.sv
// Self-checking testbench for heightmap_bilinear_sampler_unit: map writes and samples.
// It depends on hmbs_pkg, hmbs_req_if and hmbs_rsp_if, and on the unit itself.
// Heights are predicted from a private copy of the heightmap and the map size.
`timescale 1ns / 100ps

module heightmap_bilinear_sampler_unit_tb;
    import hmbs_pkg::*;

    // One whole cell in fixed-point position units, and the divisor of the height mapping.
    localparam int     CELL_ONE   = 1 << FRAC_W;
    localparam longint HEIGHT_DIV = DIV_LOW * CELL_ONE;
    localparam int     MAP_DEPTH  = 1 << ADDR_W;

    // What one response transaction carries.
    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic                       in_bounds;
    } t_height_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    hmbs_req_if req_ch ();
    hmbs_rsp_if rsp_ch ();

    heightmap_bilinear_sampler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    // Private copy of the heightmap. The written flags make sure that no sample ever
    // touches an entry that the unit still holds as unknown.
    bit [VALUE_W-1:0] height_mem    [0:MAP_DEPTH-1];
    bit               texel_written [0:MAP_DEPTH-1];

    // Map size registers as last written; the unit clamps them, the predictor does too.
    logic [CFG_W-1:0] map_width_reg  = CFG_W'(RESET_SIZE);
    logic [CFG_W-1:0] map_height_reg = CFG_W'(RESET_SIZE);

    // Heights predicted for accepted samples, oldest first.
    t_height_result pending_heights [$];

    int mismatch_count = 0;
    int items_sent     = 0;      // request transactions accepted so far
    bit idle_on        = 1'b1;   // random idle cycles on both channels
    int stall_left     = 0;      // cycles the response side still holds ready low

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The run ends here if the traffic ever stops moving.
    initial begin
        #400_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Height prediction
    // ------------------------------------------------------------------------

    function automatic int clamp_size(input logic [CFG_W-1:0] size_val, input int max_size);
        if (size_val < MIN_SIZE) return MIN_SIZE;
        if (size_val > max_size) return max_size;
        return int'(size_val);
    endfunction

    function automatic int map_cols();
        return clamp_size(map_width_reg, DEF_MAX_WIDTH);
    endfunction

    function automatic int map_rows();
        return clamp_size(map_height_reg, DEF_MAX_HEIGHT);
    endfunction

    // Shifts a position onto the map and finds the cell it falls in. Returns 0 when
    // the point lies outside the area that can be interpolated.
    function automatic bit locate_cell(input logic signed [POS_W-1:0] x, z,
                                       output int base, output int fx, output int fz);
        int cols;
        int rows;
        int xs;
        int zs;
        cols = map_cols();
        rows = map_rows();
        xs   = int'(x) + (cols / 2) * CELL_ONE;
        zs   = int'(z) + (rows / 2) * CELL_ONE;
        base = 0;
        fx   = 0;
        fz   = 0;
        if (xs < 0 || zs < 0 || xs >= (cols - 1) * CELL_ONE || zs >= (rows - 1) * CELL_ONE)
            return 1'b0;
        fx   = xs % CELL_ONE;
        fz   = zs % CELL_ONE;
        base = xs / CELL_ONE + cols * (zs / CELL_ONE);
        return 1'b1;
    endfunction

    // Bilinear weighting of the four corner bytes, then v*100/255 - 16 in 1/256 units,
    // rounded half up.
    function automatic t_height_result predict_height(input logic signed [POS_W-1:0] x, z);
        t_height_result result;
        int             base;
        int             fx;
        int             fz;
        int             cols;
        longint         weighted;
        int             quotient;
        cols = map_cols();
        if (!locate_cell(x, z, base, fx, fz)) begin
            result.height    = HEIGHT_W'(OOB_HEIGHT);
            result.in_bounds = 1'b0;
            return result;
        end
        weighted = longint'(CELL_ONE - fz) *
                       ((CELL_ONE - fx) * int'(height_mem[base]) +
                        fx * int'(height_mem[base + 1]))
                 + longint'(fz) *
                       ((CELL_ONE - fx) * int'(height_mem[base + cols]) +
                        fx * int'(height_mem[base + cols + 1]));
        quotient = int'((weighted * SCALE_NUM + ROUND_BIAS) / HEIGHT_DIV);
        result.height    = HEIGHT_W'(quotient - OFFSET_H);
        result.in_bounds = 1'b1;
        return result;
    endfunction

    // ------------------------------------------------------------------------
    // Response side: random ready, long stalls on request, and the checker
    // ------------------------------------------------------------------------

    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                rsp_ch.ready <= !(idle_on && $urandom_range(99) < 8);
            end
        end
    end

    // Every response transaction is matched against the oldest predicted height.
    always @(posedge i_clk) begin : check_response
        t_height_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_heights.size() == 0) begin
                $error("unexpected response: height %0d, in_bounds %0b",
                       rsp_ch.height, rsp_ch.in_bounds);
                mismatch_count++;
            end else begin
                want = pending_heights.pop_front();
                if (rsp_ch.height !== want.height) begin
                    $error("height: expected %0d, got %0d", want.height, rsp_ch.height);
                    mismatch_count++;
                end
                if (rsp_ch.in_bounds !== want.in_bounds) begin
                    $error("in_bounds: expected %0b, got %0b",
                           want.in_bounds, rsp_ch.in_bounds);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offers one request and returns at the edge where it is accepted. Valid stays high
    // into the next call unless that call starts with an idle gap. The predictor is
    // updated at acceptance, so writes and samples are seen in the unit's order.
    task automatic send_req(input t_action act, input logic [ADDR_W-1:0] addr,
                            input logic [VALUE_W-1:0] val,
                            input logic signed [POS_W-1:0] x, z);
        if (idle_on && $urandom_range(99) < 4) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.action        <= act;
        req_ch.texel_address <= addr;
        req_ch.texel_value   <= val;
        req_ch.x_pos         <= x;
        req_ch.z_pos         <= z;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        items_sent++;
        if (act == ACT_WRITE) begin
            height_mem[addr]    = val;
            texel_written[addr] = 1'b1;
        end else begin
            pending_heights.push_back(predict_height(x, z));
        end
    endtask

    // Position fields of a write are don't-care, so they get random bits.
    task automatic write_texel(input logic [ADDR_W-1:0] addr, input logic [VALUE_W-1:0] val);
        send_req(ACT_WRITE, addr, val, POS_W'($urandom), POS_W'($urandom));
    endtask

    function automatic logic [VALUE_W-1:0] random_texel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Samples at a position. Any corner of the cell that has never been written gets a
    // write first, since the unit's store powers up unknown.
    task automatic sample_at(input logic signed [POS_W-1:0] x, z);
        int base;
        int fx;
        int fz;
        int cols;
        int corner_addr [4];
        cols = map_cols();
        if (locate_cell(x, z, base, fx, fz)) begin
            corner_addr = '{base, base + 1, base + cols, base + cols + 1};
            foreach (corner_addr[i]) begin
                if (!texel_written[corner_addr[i]])
                    write_texel(ADDR_W'(corner_addr[i]), random_texel());
            end
        end
        send_req(ACT_SAMPLE, ADDR_W'($urandom), VALUE_W'($urandom), x, z);
    endtask

    // Lowers valid and waits until every predicted height has come back, then lets the
    // pipeline run empty: trailing writes return nothing, so they are waited out.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_heights.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // The map size may only change while nothing is in flight.
    task automatic write_map_size(input logic [CFG_W-1:0] width_val, height_val);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAP_WIDTH;
        i_cfg_data  <= width_val;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAP_HEIGHT;
        i_cfg_data  <= height_val;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        map_width_reg  = width_val;
        map_height_reg = height_val;
    endtask

    // One coordinate for a map axis of the given size: mostly inside the map, some
    // right on the edges of the legal area, some anywhere in the field's range.
    function automatic logic signed [POS_W-1:0] pick_coord(input int size);
        int          span;
        int          half;
        logic [31:0] raw;
        span = (size - 1) * CELL_ONE;
        half = (size / 2) * CELL_ONE;
        raw  = $urandom;
        case ($urandom_range(9))
            0: return raw[POS_W-1:0];
            1: begin
                case (raw[1:0])
                    2'd0:    return POS_W'(-half - 1);
                    2'd1:    return POS_W'(-half);
                    2'd2:    return POS_W'(span - 1 - half);
                    default: return POS_W'(span - half);
                endcase
            end
            default: return POS_W'(int'($urandom_range(span - 1, 0)) - half);
        endcase
    endfunction

    // The first and the last cell of the legal area, and a step past each edge.
    task automatic sample_edges();
        int half_x;
        int half_z;
        int span_x;
        int span_z;
        half_x = (map_cols() / 2) * CELL_ONE;
        half_z = (map_rows() / 2) * CELL_ONE;
        span_x = (map_cols() - 1) * CELL_ONE;
        span_z = (map_rows() - 1) * CELL_ONE;
        sample_at(POS_W'(-half_x), POS_W'(-half_z));
        sample_at(POS_W'(span_x - 1 - half_x), POS_W'(span_z - 1 - half_z));
        sample_at(POS_W'(span_x - half_x), POS_W'(-half_z));
        sample_at(POS_W'(-half_x), POS_W'(span_z - half_z));
        sample_at(POS_W'(-half_x - 1), POS_W'(-half_z));
        sample_at(POS_W'(-half_x), POS_W'(-half_z - 1));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Runs on the reset map size of 256 by 256, so the map center is cell (128, 128).
    task automatic test_directed_extremes();
        int center;
        center = 128 + 256 * 128;
        // Lowest and highest addresses with the extreme byte values.
        write_texel('0, 8'hFF);
        write_texel('1, 8'h00);
        // Four full-scale corners give the highest possible height.
        write_texel(ADDR_W'(center), 8'hFF);
        write_texel(ADDR_W'(center + 1), 8'hFF);
        write_texel(ADDR_W'(center + 256), 8'hFF);
        write_texel(ADDR_W'(center + 257), 8'hFF);
        sample_at(POS_W'(0), POS_W'(0));
        // Zero on the diagonal: a corner of weight one gives the lowest height, the
        // fractional points mix the two values.
        write_texel(ADDR_W'(center), 8'h00);
        write_texel(ADDR_W'(center + 257), 8'h00);
        sample_at(POS_W'(0), POS_W'(0));
        sample_at(POS_W'(128), POS_W'(128));
        sample_at(POS_W'(255), POS_W'(255));
        sample_at(POS_W'(255), POS_W'(0));
        // Edges of the legal area, and the extremes of the position fields.
        sample_at(POS_W'(-32768), POS_W'(-32768));
        sample_at(POS_W'(32511), POS_W'(32511));
        sample_at(POS_W'(32512), POS_W'(0));
        sample_at(POS_W'(0), POS_W'(32512));
        sample_at(POS_W'(-32769), POS_W'(0));
        sample_at(POS_W'(0), POS_W'(-32769));
        sample_at(POS_W'(-131072), POS_W'(131071));
        sample_at(POS_W'(131071), POS_W'(-131072));
    endtask

    // Sizes below two and above the maximum are clamped by the unit.
    task automatic test_size_clamping();
        write_map_size(9'd0, 9'd1);
        sample_edges();
        write_map_size(9'd511, 9'd257);
        sample_edges();
        write_map_size(9'd1, 9'd511);
        sample_edges();
        write_map_size(9'd257, 9'd0);
        sample_edges();
    endtask

    // The response side holds off long enough for all outstanding slots to fill, so the
    // request side must stall; afterwards the sender waits for every result to return.
    task automatic test_backpressure();
        write_map_size(9'd16, 9'd16);
        stall_left = 300;
        repeat (60) sample_at(pick_coord(map_cols()), pick_coord(map_rows()));
        drain_results();
    endtask

    // Mixed writes and samples on one map size, until count request transactions have
    // gone out, the corner loads included. At least half of the writes land inside the map in
    // use, so samples also see bytes overwritten after their first load.
    task automatic test_random_traffic(input logic [CFG_W-1:0] width_val, height_val,
                                       input int count, input bit with_idles);
        int stop_at;
        write_map_size(width_val, height_val);
        stop_at = items_sent + count;
        idle_on = with_idles;
        while (items_sent < stop_at) begin
            if ($urandom_range(3) == 0) begin
                if ($urandom_range(1))
                    write_texel(ADDR_W'($urandom), random_texel());
                else
                    write_texel(ADDR_W'($urandom_range(map_cols() * map_rows() - 1)),
                                random_texel());
            end else begin
                sample_at(pick_coord(map_cols()), pick_coord(map_rows()));
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_index          <= CFG_MAP_WIDTH;
        i_cfg_data           <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.action        <= ACT_WRITE;
        req_ch.texel_address <= '0;
        req_ch.texel_value   <= '0;
        req_ch.x_pos         <= '0;
        req_ch.z_pos         <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_size_clamping();
        test_backpressure();
        test_random_traffic(9'd256, 9'd256, 200, 1'b1);
        test_random_traffic(9'd2, 9'd2, 80, 1'b1);
        // One long stretch with no idle cycles on either side.
        test_random_traffic(CFG_W'($urandom_range(256, 2)), CFG_W'($urandom_range(256, 2)),
                            120, 1'b0);
        test_random_traffic(9'd3, 9'd256, 100, 1'b1);
        test_random_traffic(9'd256, 9'd3, 100, 1'b1);
        test_random_traffic(CFG_W'($urandom_range(40, 2)), CFG_W'($urandom_range(40, 2)),
                            100, 1'b1);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_heights.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
